/* rtl/spc_pkg.sv */
package spc_pkg;

  // longest segment accepted in relative mode
  localparam int unsigned MaxSegment = 255;
  // the segment counter saturates one above the limit
  localparam int unsigned SegLenW = $clog2(MaxSegment + 2);

  // check modes
  localparam logic [1:0] ModeRel    = 2'd0;
  localparam logic [1:0] ModeSingle = 2'd1;
  localparam logic [1:0] ModeIdent  = 2'd2;
  localparam logic [1:0] ModeSpare  = 2'd3;

  // characters with a meaning of their own
  localparam logic [7:0] ChFirst  = 8'h21;
  localparam logic [7:0] ChLast   = 8'h7e;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChColon  = 8'h3a;
  localparam logic [7:0] ChStar   = 8'h2a;
  localparam logic [7:0] ChQuest  = 8'h3f;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChLess   = 8'h3c;
  localparam logic [7:0] ChMore   = 8'h3e;
  localparam logic [7:0] ChPipe   = 8'h7c;
  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChUnder  = 8'h5f;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChOne    = 8'h31;
  localparam logic [7:0] ChNine   = 8'h39;

  // reserved device names, lower case
  localparam logic [23:0] NameCon = 24'h636f6e;
  localparam logic [23:0] NamePrn = 24'h70726e;
  localparam logic [23:0] NameAux = 24'h617578;
  localparam logic [23:0] NameNul = 24'h6e756c;
  localparam logic [23:0] NameCom = 24'h636f6d;
  localparam logic [23:0] NameLpt = 24'h6c7074;

  // per-string scan state
  typedef struct packed {
    logic               bad;
    logic               started;
    logic [SegLenW-1:0] seg_len;
    logic               all_dots;
    logic               prev_dot;
    logic               dot_seen;
    logic [31:0]        base_chars;
    logic [2:0]         base_len;
  } scan_t;

  localparam scan_t ScanReset = '{
    bad:        1'b0,
    started:    1'b0,
    seg_len:    '0,
    all_dots:   1'b1,
    prev_dot:   1'b0,
    dot_seen:   1'b0,
    base_chars: 32'h0,
    base_len:   3'd0
  };

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) r = c + 8'h20;
    return r;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic base_reserved(input scan_t s);
    logic [23:0] low3;
    logic [23:0] head;
    logic [7:0]  tail;
    logic        r;
    low3 = s.base_chars[23:0];
    head = s.base_chars[31:8];
    tail = s.base_chars[7:0];
    r    = 1'b0;
    if (s.base_len == 3'd3) begin
      r = (low3 == NameCon) || (low3 == NamePrn) || (low3 == NameAux) || (low3 == NameNul);
    end else if (s.base_len == 3'd4) begin
      r = ((head == NameCom) || (head == NameLpt)) && (tail >= ChOne) && (tail <= ChNine);
    end
    return r;
  endfunction

  // close the current segment and judge it
  function automatic scan_t finish_seg(input scan_t s, input logic [1:0] mode);
    scan_t r;
    r = s;
    if (s.seg_len == '0 || s.all_dots || s.prev_dot || base_reserved(s)) r.bad = 1'b1;
    if (mode == ModeRel && s.seg_len > SegLenW'(MaxSegment)) r.bad = 1'b1;
    r.seg_len    = '0;
    r.all_dots   = 1'b1;
    r.prev_dot   = 1'b0;
    r.dot_seen   = 1'b0;
    r.base_chars = 32'h0;
    r.base_len   = 3'd0;
    return r;
  endfunction

  // fold one byte into the scan state
  function automatic scan_t take_byte(input scan_t s, input logic [7:0] c,
                                      input logic [1:0] mode);
    scan_t r;
    logic  is_dot;
    r         = s;
    is_dot    = (c == ChDot);
    r.started = 1'b1;
    if (mode == ModeRel && c == ChSlash) begin
      r = finish_seg(r, mode);
    end else begin
      if (c < ChFirst || c > ChLast || c == ChSlash || c == ChBslash || c == ChColon ||
          c == ChStar || c == ChQuest || c == ChQuote || c == ChLess || c == ChMore ||
          c == ChPipe) r.bad = 1'b1;
      if (mode == ModeIdent) begin
        if (s.seg_len == '0 && !is_alnum(c)) r.bad = 1'b1;
        if (!(is_alnum(c) || is_dot || c == ChUnder || c == ChPlus || c == ChMinus))
          r.bad = 1'b1;
      end
      if (!is_dot) r.all_dots = 1'b0;
      if (is_dot) begin
        r.dot_seen = 1'b1;
      end else if (!s.dot_seen) begin
        if (s.base_len < 3'd4) r.base_chars = {s.base_chars[23:0], to_lower(c)};
        if (s.base_len < 3'd5) r.base_len = s.base_len + 3'd1;
      end
      r.prev_dot = is_dot;
      if (s.seg_len <= SegLenW'(MaxSegment)) r.seg_len = s.seg_len + SegLenW'(1);
    end
    return r;
  endfunction

endpackage

/* rtl/spc_step.sv */
module spc_step (
  input  spc_pkg::scan_t scan_i,
  input  logic [7:0]     char_code_i,
  input  logic           has_char_i,
  input  logic           last_i,
  input  logic [1:0]     mode_i,
  output spc_pkg::scan_t scan_o,
  output logic           path_ok_o
);
  import spc_pkg::*;

  logic [1:0] mode;
  scan_t      after_byte;
  scan_t      closed;

  // the spare mode code behaves as single segment
  assign mode = (mode_i == ModeSpare) ? ModeSingle : mode_i;

  // byte update, then end-of-string judgement
  always_comb begin
    after_byte = has_char_i ? take_byte(scan_i, char_code_i, mode) : scan_i;
    closed     = after_byte;
    if (!after_byte.started) closed.bad = 1'b1;
    closed     = finish_seg(closed, mode);
    path_ok_o  = !closed.bad;
    scan_o     = last_i ? ScanReset : after_byte;
  end

endmodule

/* rtl/safe_path_segment_checker_unit.sv */
// channel  | direction | tdata bits            | tuser / tlast
// s_axis   | in        | [7:0] char_code       | tuser: has_char, tlast: last
// m_axis   | out       | [0] path_ok, rest 0   | -
// cfg      | in        | cfg_data_i: check_mode | write on cfg_we_i
//
// one word accepted every cycle unless a stall on m_axis holds a last-marked word; a path_ok
// word is offered on m_axis once the word marked last has passed the input register, then the result register.
// the scan state updates in one pass between the two registers.
// a stall on m_axis holds only last-marked words; others keep flowing.
// reset clears the scan state and sets check_mode to relative paths.
module safe_path_segment_checker_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_data_i,     // check_mode
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  logic       s_axis_tuser,   // [0] has_char
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] path_ok, [7:1] zero
);
  import spc_pkg::*;

  logic [1:0] mode_q;
  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_has_q;
  logic       in_last_q;
  logic       out_valid_q;
  logic       out_ok_q;
  scan_t      scan_q;
  scan_t      scan_d;
  logic       ok_d;
  logic       advance;
  logic       s_fire;

  spc_step u_step (
    .scan_i      (scan_q),
    .char_code_i (in_char_q),
    .has_char_i  (in_has_q),
    .last_i      (in_last_q),
    .mode_i      (mode_q),
    .scan_o      (scan_d),
    .path_ok_o   (ok_d)
  );

  // a held word moves on unless it owes a result that has no room
  assign advance       = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_ok_q};

  // control and scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeRel;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      scan_q      <= ScanReset;
    end else begin
      if (cfg_we_i) mode_q <= cfg_data_i;
      if (s_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) scan_q <= scan_d;
      if (advance && in_last_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_char_q <= s_axis_tdata;
      in_has_q  <= s_axis_tuser;
      in_last_q <= s_axis_tlast;
    end
    if (advance && in_last_q) out_ok_q <= ok_d;
  end

endmodule
